[sv/tun_pkg.sv]
// ----------------------------------------------------------------------------
// tun_pkg
// shared constants for the triangle unit normal block
// ----------------------------------------------------------------------------
package tun_pkg;
    localparam int COORD_WIDTH  = 16;
    localparam int NORMAL_WIDTH = 16;
endpackage

[sv/tun_in_if.sv]
// ----------------------------------------------------------------------------
// tun_in_if
// triangle vertex channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface tun_in_if #(parameter int COORD_WIDTH = 16);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by_coord;
    logic signed [COORD_WIDTH-1:0] bz;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;

    modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
    modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

[sv/tun_out_if.sv]
// ----------------------------------------------------------------------------
// tun_out_if
// unit normal result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface tun_out_if #(parameter int NORMAL_WIDTH = 16);
    logic valid;
    logic ready;
    logic signed [NORMAL_WIDTH-1:0] normal_x;
    logic signed [NORMAL_WIDTH-1:0] normal_y;
    logic signed [NORMAL_WIDTH-1:0] normal_z;
    logic degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

[sv/triangle_unit_normal.sv]
// ----------------------------------------------------------------------------
// triangle_unit_normal
// unit face normal of a triangle, one transaction per clock
// ----------------------------------------------------------------------------
// Takes one triangle (three vertices, signed fixed point) per clock and
// returns its unit face normal in signed fixed point with NORMAL_WIDTH-2
// fraction bits, each component rounded to nearest with ties away from zero,
// plus a degenerate flag for zero-area triangles (normal then zero).
// The pipeline has six stages for edges, cross product and squared length,
// NORMAL_WIDTH-1 stages of the bit-per-stage normalizer (one result bit of
// all three components per stage, exact shift-and-add compare, no square
// root), and the output register. Throughput is one transaction per cycle;
// the whole pipeline holds while the output is stalled.
// ----------------------------------------------------------------------------
module triangle_unit_normal #(
    parameter int COORD_WIDTH  = tun_pkg::COORD_WIDTH,
    parameter int NORMAL_WIDTH = tun_pkg::NORMAL_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    tun_in_if.sink     in_ch,
    tun_out_if.source  out_ch
);
    import tun_pkg::*;

    // datapath widths
    localparam int DW   = COORD_WIDTH + 1;          // edge component
    localparam int PW   = 2 * DW;                   // product and cross component
    localparam int MW   = PW - 1;                   // cross magnitude
    localparam int HL   = (MW + 1) / 2;             // low half of magnitude
    localparam int HH   = MW - HL;                  // high half
    localparam int M2W  = 2 * MW;                   // squared magnitude
    localparam int SW   = M2W + 2;                  // squared length
    localparam int F    = NORMAL_WIDTH - 2;         // fraction bits
    localparam int QW   = F + 1;                    // result magnitude
    localparam int W    = 2 * F + 2 + SW;           // running t*t*s
    localparam int CMPW = W + 2;                    // compare width

    // global pipeline enable: everything moves when the output can
    logic en;
    logic out_valid_reg;
    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // stage 1: edge vectors
    logic v1_reg;
    logic signed [DW-1:0] d_reg [0:2];
    logic signed [DW-1:0] e_reg [0:2];
    logic signed [DW-1:0] d_next [0:2];
    logic signed [DW-1:0] e_next [0:2];

    always_comb
    begin
        d_next[0] = DW'(in_ch.bx) - DW'(in_ch.ax);
        d_next[1] = DW'(in_ch.by_coord) - DW'(in_ch.ay);
        d_next[2] = DW'(in_ch.bz) - DW'(in_ch.az);
        e_next[0] = DW'(in_ch.cx) - DW'(in_ch.ax);
        e_next[1] = DW'(in_ch.cy) - DW'(in_ch.ay);
        e_next[2] = DW'(in_ch.cz) - DW'(in_ch.az);
    end

    // stage 2: six products of the cross product
    logic v2_reg;
    logic signed [PW-1:0] p_reg [0:5];

    // stage 3: cross components as sign and magnitude
    logic v3_reg;
    logic [MW-1:0] mag_reg [0:2];
    logic          neg3_reg [0:2];
    logic signed [PW-1:0] n_next [0:2];

    always_comb
    begin
        n_next[0] = p_reg[0] - p_reg[1];
        n_next[1] = p_reg[2] - p_reg[3];
        n_next[2] = p_reg[4] - p_reg[5];
    end

    // stage 4: partial squares, stage 5: squares, stage 6: squared length
    logic v4_reg, v5_reg, v6_reg;
    logic [2*HH-1:0]   hh_reg [0:2];
    logic [HH+HL-1:0]  hl_reg [0:2];
    logic [2*HL-1:0]   ll_reg [0:2];
    logic              neg4_reg [0:2];
    logic [M2W-1:0]    m2_5_reg [0:2];
    logic              neg5_reg [0:2];
    logic [M2W-1:0]    m2_6_reg [0:2];
    logic              neg6_reg [0:2];
    logic [SW-1:0]     s6_reg;
    logic [SW-1:0]     s_next;
    assign s_next = SW'(m2_5_reg[0]) + SW'(m2_5_reg[1]) + SW'(m2_5_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i] <= d_next[i];
                e_reg[i] <= e_next[i];
                neg3_reg[i] <= n_next[i][PW-1];
                mag_reg[i]  <= n_next[i][PW-1] ? MW'(-n_next[i]) : MW'(n_next[i]);
                hh_reg[i] <= mag_reg[i][MW-1:HL] * mag_reg[i][MW-1:HL];
                hl_reg[i] <= mag_reg[i][MW-1:HL] * mag_reg[i][HL-1:0];
                ll_reg[i] <= mag_reg[i][HL-1:0] * mag_reg[i][HL-1:0];
                neg4_reg[i] <= neg3_reg[i];
                m2_5_reg[i] <= (M2W'(hh_reg[i]) << (2 * HL))
                             + (M2W'(hl_reg[i]) << (HL + 1))
                             + M2W'(ll_reg[i]);
                neg5_reg[i] <= neg4_reg[i];
                m2_6_reg[i] <= m2_5_reg[i];
                neg6_reg[i] <= neg5_reg[i];
            end
            p_reg[0] <= d_reg[1] * e_reg[2];
            p_reg[1] <= e_reg[1] * d_reg[2];
            p_reg[2] <= d_reg[2] * e_reg[0];
            p_reg[3] <= d_reg[0] * e_reg[2];
            p_reg[4] <= d_reg[0] * e_reg[1];
            p_reg[5] <= e_reg[0] * d_reg[1];
            s6_reg <= s_next;
        end
    end

    // normalizer: stage k settles result bit F-k of each component by the
    // test (2t-1)^2 * s <= m^2 * 2^(2F+2), with t*t*s and t*s kept running
    logic              vi_reg  [0:F];
    logic [QW-1:0]     q_reg   [0:F][0:2];
    logic [W-1:0]      t2_reg  [0:F][0:2];
    logic [W-1:0]      t1_reg  [0:F][0:2];
    logic [M2W-1:0]    m2_reg  [0:F][0:2];
    logic              neg_reg [0:F][0:2];
    logic [SW-1:0]     s_reg   [0:F];

    for (genvar k = 0; k <= F; k++)
    begin : g_step
        localparam int B = F - k;
        logic             vin;
        logic [SW-1:0]    sin;
        logic [QW-1:0]    qin   [0:2];
        logic [W-1:0]     t2in  [0:2];
        logic [W-1:0]     t1in  [0:2];
        logic [M2W-1:0]   m2in  [0:2];
        logic             negin [0:2];
        logic [QW-1:0]    q_next  [0:2];
        logic [W-1:0]     t2_next [0:2];
        logic [W-1:0]     t1_next [0:2];

        if (k == 0)
        begin : g_first
            always_comb
            begin
                vin = v6_reg;
                sin = s6_reg;
                for (int l = 0; l < 3; l++)
                begin
                    qin[l]   = '0;
                    t2in[l]  = '0;
                    t1in[l]  = '0;
                    m2in[l]  = m2_6_reg[l];
                    negin[l] = neg6_reg[l];
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                vin = vi_reg[k-1];
                sin = s_reg[k-1];
                for (int l = 0; l < 3; l++)
                begin
                    qin[l]   = q_reg[k-1][l];
                    t2in[l]  = t2_reg[k-1][l];
                    t1in[l]  = t1_reg[k-1][l];
                    m2in[l]  = m2_reg[k-1][l];
                    negin[l] = neg_reg[k-1][l];
                end
            end
        end

        always_comb
        begin
            logic [CMPW-1:0] se;
            logic [CMPW-1:0] t2t;
            logic [CMPW-1:0] t1t;
            logic [CMPW-1:0] odd2;
            logic [CMPW-1:0] rhs;
            se = CMPW'(sin);
            for (int l = 0; l < 3; l++)
            begin
                t2t  = CMPW'(t2in[l]) + (CMPW'(t1in[l]) << (B + 1)) + (se << (2 * B));
                t1t  = CMPW'(t1in[l]) + (se << B);
                odd2 = (t2t << 2) - (t1t << 2) + se;
                rhs  = CMPW'(m2in[l]) << (2 * F + 2);
                if (odd2 <= rhs)
                begin
                    q_next[l]  = qin[l] | (QW'(1) << B);
                    t2_next[l] = W'(t2t);
                    t1_next[l] = W'(t1t);
                end
                else
                begin
                    q_next[l]  = qin[l];
                    t2_next[l] = t2in[l];
                    t1_next[l] = t1in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vi_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vi_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[k] <= sin;
                for (int l = 0; l < 3; l++)
                begin
                    q_reg[k][l]   <= q_next[l];
                    t2_reg[k][l]  <= t2_next[l];
                    t1_reg[k][l]  <= t1_next[l];
                    m2_reg[k][l]  <= m2in[l];
                    neg_reg[k][l] <= negin[l];
                end
            end
        end
    end

    // output register: sign applied, zero-area triangles flagged
    logic signed [NORMAL_WIDTH-1:0] nrm_reg  [0:2];
    logic signed [NORMAL_WIDTH-1:0] nrm_next [0:2];
    logic                           degen_reg;
    logic                           degen_next;

    always_comb
    begin
        degen_next = (s_reg[F] == '0);
        for (int l = 0; l < 3; l++)
        begin
            if (degen_next)
                nrm_next[l] = '0;
            else if (neg_reg[F][l])
                nrm_next[l] = -NORMAL_WIDTH'(q_reg[F][l]);
            else
                nrm_next[l] = NORMAL_WIDTH'(q_reg[F][l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vi_reg[F];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_reg <= degen_next;
            for (int l = 0; l < 3; l++)
                nrm_reg[l] <= nrm_next[l];
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.normal_x   = nrm_reg[0];
    assign out_ch.normal_y   = nrm_reg[1];
    assign out_ch.normal_z   = nrm_reg[2];
    assign out_ch.degenerate = degen_reg;

    // a zero-area triangle always gives a zero normal
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.degenerate |->
            out_ch.normal_x == '0 && out_ch.normal_y == '0 && out_ch.normal_z == '0)
        else $error("degenerate transaction with nonzero normal");

    // a real triangle has a unit normal, never all zero
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.degenerate |->
            out_ch.normal_x != '0 || out_ch.normal_y != '0 || out_ch.normal_z != '0)
        else $error("nondegenerate transaction with zero normal");

    // an accepted transaction enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> v1_reg)
        else $error("accepted transaction lost at pipeline entry");

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the triangle unit normal block
// ----------------------------------------------------------------------------
// Drives triangles through the vertex channel with random gaps and stalls the
// result channel at random. Every accepted triangle is turned into an exact
// expected unit normal by a predictor that works in wide integers, and each
// returned transaction is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module testbench;
    import tun_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int NW = NORMAL_WIDTH;
    localparam int FB = NW - 2;
    localparam int LATENCY = NW + 6;
    localparam int N_RANDOM = 800;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [NW-1:0] comp_t;

    typedef struct packed {
        coord_t ax, ay, az, bx, by_coord, bz, cx, cy, cz;
    } tri_t;

    typedef struct packed {
        comp_t nx, ny, nz;
        logic  degenerate;
    } normal_t;

    // rounded magnitude of m * 2^FB / sqrt(s), ties away from zero;
    // bit q is kept when (2q-1)^2 * s <= m^2 * 4^(FB+1)
    function automatic logic [NW-1:0] unit_mag(logic [255:0] m, logic [255:0] s);
        logic [255:0] rhs;
        logic [255:0] odd;
        logic [NW-1:0] q;
        logic [NW-1:0] t;
        rhs = (m * m) << (2 * FB + 2);
        q = '0;
        for (int b = FB; b >= 0; b--)
        begin
            t = q | (NW'(1) << b);
            odd = 256'(2 * t) - 256'd1;
            if (odd * odd * s <= rhs)
                q = t;
        end
        return q;
    endfunction

    function automatic normal_t face_normal(tri_t v);
        logic signed [255:0] d [3];
        logic signed [255:0] e [3];
        logic signed [255:0] n [3];
        logic [255:0] m [3];
        logic [255:0] s;
        logic [NW-1:0] q;
        comp_t c [3];
        normal_t r;
        d[0] = 256'(v.bx) - 256'(v.ax);
        d[1] = 256'(v.by_coord) - 256'(v.ay);
        d[2] = 256'(v.bz) - 256'(v.az);
        e[0] = 256'(v.cx) - 256'(v.ax);
        e[1] = 256'(v.cy) - 256'(v.ay);
        e[2] = 256'(v.cz) - 256'(v.az);
        n[0] = d[1] * e[2] - e[1] * d[2];
        n[1] = d[2] * e[0] - d[0] * e[2];
        n[2] = d[0] * e[1] - e[0] * d[1];
        for (int i = 0; i < 3; i++)
            m[i] = n[i] < 0 ? -n[i] : n[i];
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        r = '0;
        if (s == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            q = unit_mag(m[i], s);
            c[i] = n[i] < 0 ? comp_t'(-q) : comp_t'(q);
        end
        r.nx = c[0];
        r.ny = c[1];
        r.nz = c[2];
        return r;
    endfunction

    class normal_scoreboard;
        normal_t pending[$];
        int errors;
        int checked;
        int degenerate_seen;

        function void note_triangle(tri_t v);
            pending.push_back(face_normal(v));
        endfunction

        function void check_normal(normal_t got);
            normal_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.degenerate)
                degenerate_seen++;
            if (got.nx !== want.nx)
            begin
                $display("%0t: normal_x expected %0d actual %0d", $time, want.nx, got.nx);
                errors++;
            end
            if (got.ny !== want.ny)
            begin
                $display("%0t: normal_y expected %0d actual %0d", $time, want.ny, got.ny);
                errors++;
            end
            if (got.nz !== want.nz)
            begin
                $display("%0t: normal_z expected %0d actual %0d", $time, want.nz, got.nz);
                errors++;
            end
            if (got.degenerate !== want.degenerate)
            begin
                $display("%0t: degenerate expected %0b actual %0b", $time,
                         want.degenerate, got.degenerate);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    longint cycles;

    tun_in_if #(.COORD_WIDTH(CW)) in_ch ();
    tun_out_if #(.NORMAL_WIDTH(NW)) out_ch ();

    triangle_unit_normal #(
        .COORD_WIDTH  (CW),
        .NORMAL_WIDTH (NW)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    normal_scoreboard sb = new();

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle counter doubles as the watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // sample the result channel at the rising edge
    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_normal({out_ch.normal_x, out_ch.normal_y, out_ch.normal_z,
                             out_ch.degenerate});

    // note every accepted triangle at the rising edge
    always @(posedge clk)
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_triangle({in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by_coord,
                              in_ch.bz, in_ch.cx, in_ch.cy, in_ch.cz});

    // receiver: ready toggles with random stall lengths, with calm stretches
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (($urandom_range(0, 199) < 60))
            begin
                gap = $urandom_range(0, 18);
                if (gap > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(20, 60)) @(negedge clk);
        end
    end

    // send one triangle; gap idles first, valid stays high across back-to-back sends
    task automatic send_triangle(tri_t v, int gap);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.ax       <= v.ax;
        in_ch.ay       <= v.ay;
        in_ch.az       <= v.az;
        in_ch.bx       <= v.bx;
        in_ch.by_coord <= v.by_coord;
        in_ch.bz       <= v.bz;
        in_ch.cx       <= v.cx;
        in_ch.cy       <= v.cy;
        in_ch.cz       <= v.cz;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 512)) - 256);
            2: return $urandom_range(0, 1) ? coord_t'(-32768) : coord_t'(32767);
            default: return coord_t'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    // mostly random triangles; some collinear or repeated vertices for zero area
    function automatic tri_t random_triangle();
        tri_t v;
        int mode;
        int k;
        mode = $urandom_range(0, 3);
        v = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode)};
        case ($urandom_range(0, 15))
            0:
            begin
                v.bx = v.ax; v.by_coord = v.ay; v.bz = v.az;
            end
            1:
            begin
                // c = a + k*(b - a), collinear when no wrap occurs
                k = $signed($urandom_range(0, 4)) - 2;
                v = {rand_coord(1), rand_coord(1), rand_coord(1),
                     rand_coord(1), rand_coord(1), rand_coord(1), 48'd0};
                v.cx = coord_t'(v.ax + k * (v.bx - v.ax));
                v.cy = coord_t'(v.ay + k * (v.by_coord - v.ay));
                v.cz = coord_t'(v.az + k * (v.bz - v.az));
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 18)) : 0;
    endfunction

    initial
    begin
        tri_t directed[$];
        coord_t lo;
        coord_t hi;
        int waited;
        lo = coord_t'(-32768);
        hi = coord_t'(32767);
        cycles = 0;
        in_ch.valid = 1'b0;
        {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by_coord, in_ch.bz,
         in_ch.cx, in_ch.cy, in_ch.cz} = '0;
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: axis-aligned, both winding orders, zero area, full-range extremes
        directed.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0,
                            16'sd0, 16'sd4096, 16'sd0});
        directed.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0,
                            16'sd4096, 16'sd0, 16'sd0});
        directed.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096,
                            16'sd4096, 16'sd0, 16'sd0});
        directed.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd4096, 16'sd0,
                            16'sd0, 16'sd4096, 16'sd4096});
        directed.push_back('0);
        directed.push_back({hi, hi, hi, hi, hi, hi, hi, hi, hi});
        directed.push_back({16'sd1, 16'sd2, 16'sd3, 16'sd2, 16'sd4, 16'sd6,
                            16'sd3, 16'sd6, 16'sd9});
        directed.push_back({lo, lo, lo, hi, lo, lo, lo, hi, lo});
        directed.push_back({hi, hi, hi, lo, hi, hi, hi, lo, hi});
        directed.push_back({lo, lo, lo, hi, hi, lo, lo, hi, hi});
        directed.push_back({lo, hi, lo, hi, lo, hi, hi, hi, lo});
        directed.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0,
                            16'sd0, 16'sd1, 16'sd0});
        directed.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0,
                            16'sd1, 16'sd0, 16'sd1});
        directed.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0,
                            16'sd0, 16'sd0, 16'sd1});
        directed.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1,
                            16'sd2, 16'sd3, 16'sd5});
        directed.push_back({16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
                            16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA});
        foreach (directed[i])
            send_triangle(directed[i], draw_gap());

        // random part: bursts without gaps mixed with idle stretches
        for (int i = 0; i < N_RANDOM; i++)
            send_triangle(random_triangle(), (i % 200 < 60) ? 0 : draw_gap());
        in_ch.valid <= 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (4 * LATENCY) @(negedge clk);

        $display("checked %0d normals, %0d of them degenerate, from %0d triangles",
                 sb.checked, sb.degenerate_seen, directed.size() + N_RANDOM);
        $display("random gaps on both channels, full-range and small coordinates");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[files.f]
sv/tun_pkg.sv
sv/tun_in_if.sv
sv/tun_out_if.sv
sv/triangle_unit_normal.sv
verif/testbench.sv
